### rtl/sks_pkg.sv
// shared constants and types for the stable key sorter
package sks_pkg;

    localparam int SKS_MAX_ITEMS = 64;
    localparam int SKS_KEY_BITS  = 16;
    localparam int TAG_BITS      = 16;
    localparam int KEY_PORT_BITS = 16;

    typedef struct packed {
        logic insert;
        logic drain;
    } cell_ctrl_t;

endpackage

### rtl/sks_cell.sv
// one slot of the sorting chain: holds a key and tag, inserts or shifts in step with its neighbors
module sks_cell #(
    parameter int KEY_W = sks_pkg::SKS_KEY_BITS
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  sks_pkg::cell_ctrl_t         ctrl,
    input  logic [KEY_W-1:0]            new_key,
    input  logic [sks_pkg::TAG_BITS-1:0] new_tag,
    input  logic                        prev_gt,
    input  logic [KEY_W-1:0]            left_key,
    input  logic [sks_pkg::TAG_BITS-1:0] left_tag,
    input  logic                        left_valid,
    input  logic [KEY_W-1:0]            right_key,
    input  logic [sks_pkg::TAG_BITS-1:0] right_tag,
    input  logic                        right_valid,
    output logic                        gt,
    output logic [KEY_W-1:0]            key,
    output logic [sks_pkg::TAG_BITS-1:0] tag,
    output logic                        valid
);
    import sks_pkg::*;

    logic [KEY_W-1:0]    key_reg, key_next;
    logic [TAG_BITS-1:0] tag_reg, tag_next;
    logic                valid_reg, valid_next;

    // first slot holding a larger key takes the new item, so equal keys keep arrival order
    assign gt = !valid_reg || (key_reg > new_key);

    always_comb
    begin
        key_next   = key_reg;
        tag_next   = tag_reg;
        valid_next = valid_reg;
        if (ctrl.insert && gt)
        begin
            if (prev_gt)
            begin
                key_next   = left_key;
                tag_next   = left_tag;
                valid_next = left_valid;
            end
            else
            begin
                key_next   = new_key;
                tag_next   = new_tag;
                valid_next = 1'b1;
            end
        end
        else if (ctrl.drain)
        begin
            key_next   = right_key;
            tag_next   = right_tag;
            valid_next = right_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        tag_reg <= tag_next;
    end

    assign key   = key_reg;
    assign tag   = tag_reg;
    assign valid = valid_reg;

endmodule

### rtl/stable_key_sort.sv
// top level of the stable key sorter: control and the chain of sorting cells
//
// Items are offered on item_tag, item_key and final_item with start; a transfer
// happens at a clock edge where start is high and busy is low. Each item is
// placed into its sorted position in the cell chain in the cycle it is taken,
// so loading runs at one item per cycle. Up to MAX_ITEMS items are held; any
// further item of the same set is dropped and overflowed is raised on every
// result of that set. An item with final_item set (stored or dropped) ends the
// set: from the next cycle busy is high and the chain shifts toward cell zero,
// giving one result per cycle on out_tag, out_key, out_last and overflowed,
// marked by out_valid, in ascending key order with equal keys in arrival order.
// The last result carries out_last, after which busy falls and the block is empty.
// Results are shown for exactly one cycle and cannot be held off. Reset empties
// the chain, clears the overflow flag and returns the block to idle.
module stable_key_sort #(
    parameter int MAX_ITEMS = sks_pkg::SKS_MAX_ITEMS,
    parameter int KEY_BITS  = sks_pkg::SKS_KEY_BITS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [sks_pkg::TAG_BITS-1:0]      item_tag,
    input  logic [sks_pkg::KEY_PORT_BITS-1:0] item_key,
    input  logic                              final_item,
    output logic                              out_valid,
    output logic [sks_pkg::TAG_BITS-1:0]      out_tag,
    output logic [sks_pkg::KEY_PORT_BITS-1:0] out_key,
    output logic                              out_last,
    output logic                              overflowed
);
    import sks_pkg::*;

    localparam int KEY_W = (KEY_BITS < KEY_PORT_BITS) ? KEY_BITS : KEY_PORT_BITS;
    localparam int CNT_W = $clog2(MAX_ITEMS + 1);

    typedef enum logic {
        ST_LOAD,
        ST_EMIT
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               dropped_reg, dropped_next;
    logic               accept;
    logic               room;
    cell_ctrl_t         ctrl;
    logic [KEY_W-1:0]   new_key;

    logic [KEY_W-1:0]    cell_key   [MAX_ITEMS];
    logic [TAG_BITS-1:0] cell_tag   [MAX_ITEMS];
    logic                cell_valid [MAX_ITEMS];
    logic                cell_gt    [MAX_ITEMS];

    assign busy    = (state_reg == ST_EMIT);
    assign accept  = start && !busy;
    assign room    = (count_reg < CNT_W'(MAX_ITEMS));
    assign new_key = item_key[KEY_W-1:0];

    assign ctrl.insert = accept && room;
    assign ctrl.drain  = busy;

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        dropped_next = dropped_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (accept)
                begin
                    if (room)
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                    else
                    begin
                        dropped_next = 1'b1;
                    end
                    if (final_item)
                    begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_EMIT:
            begin
                count_next = count_reg - CNT_W'(1);
                if (count_reg == CNT_W'(1))
                begin
                    state_next   = ST_LOAD;
                    dropped_next = 1'b0;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_LOAD;
            count_reg   <= '0;
            dropped_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            dropped_reg <= dropped_next;
        end
    end

    genvar i;
    generate
        for (i = 0; i < MAX_ITEMS; i++)
        begin : g_cell
            logic                prev_gt;
            logic [KEY_W-1:0]    left_key, right_key;
            logic [TAG_BITS-1:0] left_tag, right_tag;
            logic                left_valid, right_valid;

            if (i == 0)
            begin : g_first
                assign prev_gt    = 1'b0;
                assign left_key   = '0;
                assign left_tag   = '0;
                assign left_valid = 1'b0;
            end
            else
            begin : g_inner_left
                assign prev_gt    = cell_gt[i-1];
                assign left_key   = cell_key[i-1];
                assign left_tag   = cell_tag[i-1];
                assign left_valid = cell_valid[i-1];
            end

            if (i == MAX_ITEMS - 1)
            begin : g_last
                assign right_key   = '0;
                assign right_tag   = '0;
                assign right_valid = 1'b0;
            end
            else
            begin : g_inner_right
                assign right_key   = cell_key[i+1];
                assign right_tag   = cell_tag[i+1];
                assign right_valid = cell_valid[i+1];
            end

            sks_cell #(
                .KEY_W (KEY_W)
            ) u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctrl        (ctrl),
                .new_key     (new_key),
                .new_tag     (item_tag),
                .prev_gt     (prev_gt),
                .left_key    (left_key),
                .left_tag    (left_tag),
                .left_valid  (left_valid),
                .right_key   (right_key),
                .right_tag   (right_tag),
                .right_valid (right_valid),
                .gt          (cell_gt[i]),
                .key         (cell_key[i]),
                .tag         (cell_tag[i]),
                .valid       (cell_valid[i])
            );
        end
    endgenerate

    // results leave from the head of the chain
    assign out_valid  = busy;
    assign out_tag    = cell_tag[0];
    assign out_key    = KEY_PORT_BITS'(cell_key[0]);
    assign out_last   = busy && (count_reg == CNT_W'(1));
    assign overflowed = dropped_reg;

endmodule
